// ----- sv/qvr_pkg.sv -----
`timescale 1ns / 1ps

package qvr_pkg;

    // Field widths of the payload
    localparam int VEC_WIDTH = 16;
    localparam int QUAT_BITS = 16;

    typedef struct packed {
        logic signed [VEC_WIDTH-1:0] vec_x;
        logic signed [VEC_WIDTH-1:0] vec_y;
        logic signed [VEC_WIDTH-1:0] vec_z;
        logic signed [QUAT_BITS-1:0] quat_w;
        logic signed [QUAT_BITS-1:0] quat_x;
        logic signed [QUAT_BITS-1:0] quat_y;
        logic signed [QUAT_BITS-1:0] quat_z;
    } qvr_in_t;

    typedef struct packed {
        logic signed [VEC_WIDTH-1:0] out_x;
        logic signed [VEC_WIDTH-1:0] out_y;
        logic signed [VEC_WIDTH-1:0] out_z;
        logic                        saturated;
    } qvr_out_t;

endpackage

// ----- sv/qvr_round_sat.sv -----
`timescale 1ns / 1ps

module qvr_round_sat #(
    parameter int ACC_W  = 52,
    parameter int SUM_W  = 53,
    parameter int SHIFT  = 28,
    parameter int OUT_W  = 16
) (
    input  logic signed [ACC_W-1:0] acc,
    output logic signed [OUT_W-1:0] result,
    output logic                    clip
);

    localparam logic signed [SUM_W-1:0] HALF = SUM_W'(1) << (SHIFT - 1);
    localparam logic signed [SUM_W-1:0] HI   = (SUM_W'(1) << (OUT_W - 1)) - SUM_W'(1);
    localparam logic signed [SUM_W-1:0] LO   = -HI - SUM_W'(1);

    logic signed [SUM_W-1:0] sum;
    logic signed [SUM_W-1:0] scaled;

    always_comb
    begin
        // add half an output step, ties go toward plus infinity
        sum    = SUM_W'(acc) + HALF;
        scaled = sum >>> SHIFT;
        if (scaled > HI)
        begin
            result = HI[OUT_W-1:0];
            clip   = 1'b1;
        end
        else if (scaled < LO)
        begin
            result = LO[OUT_W-1:0];
            clip   = 1'b1;
        end
        else
        begin
            result = scaled[OUT_W-1:0];
            clip   = 1'b0;
        end
    end

endmodule

// ----- sv/quaternion_vector_rotate_unit.sv -----
`timescale 1ns / 1ps

// Rotates a 3-vector by a quaternion: r = q * (0,v) * conj(q).
// Input channel in_valid/in_ready/in_data carries the vector and the Q2.14
// quaternion; output channel out_valid/out_ready/out_data carries the rotated
// vector, rounded to nearest, saturated, plus a flag set if any part clipped.
// Pipeline of five register stages: first-product multipliers, first sums,
// second-product multipliers, second sums, round and saturate into the
// output register. out_valid is the valid bit of that output register, so
// a result can leave once its transaction has passed through every stage.
// Throughput is one transaction per cycle unless out_ready stalls it; each
// stage has a valid bit, takes new data when empty or when its successor moves.
// When the receiver holds out_ready low the pipeline keeps filling until all
// five stages are full, then in_ready drops; nothing is lost or repeated.
// Reset clears all valid bits, so the block comes up empty with in_ready
// high; the payload registers are not reset.
module quaternion_vector_rotate_unit #(
    parameter int QUAT_FRAC_BITS = 14
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  qvr_pkg::qvr_in_t in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output qvr_pkg::qvr_out_t out_data
);

    localparam int VW        = qvr_pkg::VEC_WIDTH;
    localparam int QW        = qvr_pkg::QUAT_BITS;
    localparam int OUT_SHIFT = 2 * QUAT_FRAC_BITS;
    localparam int P1W       = VW + QW;
    localparam int TW        = P1W + 2;
    localparam int P2W       = TW + QW;
    localparam int FULL_W    = P2W + 2;
    localparam int ACC_W     = (FULL_W > 64) ? 64 : FULL_W;
    localparam int WIDE_W    = (FULL_W + 1 > OUT_SHIFT + 1) ? FULL_W + 1 : OUT_SHIFT + 1;
    localparam int SUM_W     = (FULL_W >= 64) ? 64 : WIDE_W;

    // stage valid bits and enables
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic en1, en2, en3, en4, en5;

    assign en5      = !v5_reg || out_ready;
    assign en4      = !v4_reg || en5;
    assign en3      = !v3_reg || en4;
    assign en2      = !v2_reg || en3;
    assign en1      = !v1_reg || en2;
    assign in_ready = en1;

    // stage 1: first products q * v
    logic signed [P1W-1:0] a_reg [12];
    logic signed [QW-1:0]  q1_reg [4];

    // stage 2: t = q * (0,v)
    logic signed [TW-1:0]  t_reg [4];
    logic signed [QW-1:0]  q2_reg [4];

    // stage 3: second products t * q
    logic signed [P2W-1:0] c_reg [12];

    // stage 4: vector part of t * conj(q)
    logic signed [ACC_W-1:0] r_reg [3];

    logic signed [P1W-1:0]   a_next [12];
    logic signed [TW-1:0]    t_next [4];
    logic signed [P2W-1:0]   c_next [12];
    logic signed [FULL_W-1:0] r_full [3];

    qvr_pkg::qvr_out_t out_reg;
    qvr_pkg::qvr_out_t out_next;

    always_comb
    begin
        a_next[0]  = P1W'(in_data.quat_x) * P1W'(in_data.vec_x);
        a_next[1]  = P1W'(in_data.quat_y) * P1W'(in_data.vec_y);
        a_next[2]  = P1W'(in_data.quat_z) * P1W'(in_data.vec_z);
        a_next[3]  = P1W'(in_data.quat_w) * P1W'(in_data.vec_x);
        a_next[4]  = P1W'(in_data.quat_y) * P1W'(in_data.vec_z);
        a_next[5]  = P1W'(in_data.quat_z) * P1W'(in_data.vec_y);
        a_next[6]  = P1W'(in_data.quat_w) * P1W'(in_data.vec_y);
        a_next[7]  = P1W'(in_data.quat_x) * P1W'(in_data.vec_z);
        a_next[8]  = P1W'(in_data.quat_z) * P1W'(in_data.vec_x);
        a_next[9]  = P1W'(in_data.quat_w) * P1W'(in_data.vec_z);
        a_next[10] = P1W'(in_data.quat_x) * P1W'(in_data.vec_y);
        a_next[11] = P1W'(in_data.quat_y) * P1W'(in_data.vec_x);
    end

    always_comb
    begin
        t_next[0] = -TW'(a_reg[0]) - TW'(a_reg[1]) - TW'(a_reg[2]);
        t_next[1] =  TW'(a_reg[3]) + TW'(a_reg[4]) - TW'(a_reg[5]);
        t_next[2] =  TW'(a_reg[6]) - TW'(a_reg[7]) + TW'(a_reg[8]);
        t_next[3] =  TW'(a_reg[9]) + TW'(a_reg[10]) - TW'(a_reg[11]);
    end

    // q2_reg order: w, x, y, z
    always_comb
    begin
        c_next[0]  = P2W'(t_reg[0]) * P2W'(q2_reg[1]);
        c_next[1]  = P2W'(t_reg[1]) * P2W'(q2_reg[0]);
        c_next[2]  = P2W'(t_reg[2]) * P2W'(q2_reg[3]);
        c_next[3]  = P2W'(t_reg[3]) * P2W'(q2_reg[2]);
        c_next[4]  = P2W'(t_reg[0]) * P2W'(q2_reg[2]);
        c_next[5]  = P2W'(t_reg[1]) * P2W'(q2_reg[3]);
        c_next[6]  = P2W'(t_reg[2]) * P2W'(q2_reg[0]);
        c_next[7]  = P2W'(t_reg[3]) * P2W'(q2_reg[1]);
        c_next[8]  = P2W'(t_reg[0]) * P2W'(q2_reg[3]);
        c_next[9]  = P2W'(t_reg[1]) * P2W'(q2_reg[2]);
        c_next[10] = P2W'(t_reg[2]) * P2W'(q2_reg[1]);
        c_next[11] = P2W'(t_reg[3]) * P2W'(q2_reg[0]);
    end

    // conj(q) signs are folded into the sums
    always_comb
    begin
        r_full[0] = -FULL_W'(c_reg[0]) + FULL_W'(c_reg[1])
                    - FULL_W'(c_reg[2]) + FULL_W'(c_reg[3]);
        r_full[1] = -FULL_W'(c_reg[4]) + FULL_W'(c_reg[5])
                    + FULL_W'(c_reg[6]) - FULL_W'(c_reg[7]);
        r_full[2] = -FULL_W'(c_reg[8]) - FULL_W'(c_reg[9])
                    + FULL_W'(c_reg[10]) + FULL_W'(c_reg[11]);
    end

    logic clip_x, clip_y, clip_z;

    qvr_round_sat #(
        .ACC_W (ACC_W),
        .SUM_W (SUM_W),
        .SHIFT (OUT_SHIFT),
        .OUT_W (VW)
    ) u_round_x (
        .acc    (r_reg[0]),
        .result (out_next.out_x),
        .clip   (clip_x)
    );

    qvr_round_sat #(
        .ACC_W (ACC_W),
        .SUM_W (SUM_W),
        .SHIFT (OUT_SHIFT),
        .OUT_W (VW)
    ) u_round_y (
        .acc    (r_reg[1]),
        .result (out_next.out_y),
        .clip   (clip_y)
    );

    qvr_round_sat #(
        .ACC_W (ACC_W),
        .SUM_W (SUM_W),
        .SHIFT (OUT_SHIFT),
        .OUT_W (VW)
    ) u_round_z (
        .acc    (r_reg[2]),
        .result (out_next.out_z),
        .clip   (clip_z)
    );

    assign out_next.saturated = clip_x || clip_y || clip_z;

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else
        begin
            if (en1)
            begin
                v1_reg <= in_valid;
            end
            if (en2)
            begin
                v2_reg <= v1_reg;
            end
            if (en3)
            begin
                v3_reg <= v2_reg;
            end
            if (en4)
            begin
                v4_reg <= v3_reg;
            end
            if (en5)
            begin
                v5_reg <= v4_reg;
            end
        end
    end

    // payload, advanced with the stage enables
    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            a_reg     <= a_next;
            q1_reg[0] <= in_data.quat_w;
            q1_reg[1] <= in_data.quat_x;
            q1_reg[2] <= in_data.quat_y;
            q1_reg[3] <= in_data.quat_z;
        end
        if (en2)
        begin
            t_reg  <= t_next;
            q2_reg <= q1_reg;
        end
        if (en3)
        begin
            c_reg <= c_next;
        end
        if (en4)
        begin
            r_reg[0] <= r_full[0][ACC_W-1:0];
            r_reg[1] <= r_full[1][ACC_W-1:0];
            r_reg[2] <= r_full[2][ACC_W-1:0];
        end
        if (en5)
        begin
            out_reg <= out_next;
        end
    end

    assign out_valid = v5_reg;
    assign out_data  = out_reg;

    localparam logic signed [VW-1:0] OUT_MAX = {1'b0, {(VW-1){1'b1}}};
    localparam logic signed [VW-1:0] OUT_MIN = {1'b1, {(VW-1){1'b0}}};

    logic [2:0] occupancy;
    assign occupancy = 3'($countones({v1_reg, v2_reg, v3_reg, v4_reg, v5_reg}));

    // occupancy tracks accepted minus delivered transactions
    a_occ_in : assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && !(out_valid && out_ready))
        |=> occupancy == $past(occupancy) + 3'd1)
        else $error("transaction lost or duplicated on input side");

    a_occ_out : assert property (@(posedge clk) disable iff (!rst_n)
        (!(in_valid && in_ready) && out_valid && out_ready)
        |=> occupancy == $past(occupancy) - 3'd1)
        else $error("transaction lost or duplicated on output side");

    a_occ_hold : assert property (@(posedge clk) disable iff (!rst_n)
        ((in_valid && in_ready) == (out_valid && out_ready))
        |=> occupancy == $past(occupancy))
        else $error("occupancy changed without a transaction");

    // with stages four and five full and the output stalled, stage four must hold
    a_stall_hold : assert property (@(posedge clk) disable iff (!rst_n)
        (v4_reg && v5_reg && !out_ready) |=> v4_reg && $stable(r_reg[0]))
        else $error("stage four advanced while output stalled");

    // clipped flag implies some component sits on a bound
    a_sat_bound : assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.saturated)
        |-> (out_data.out_x == OUT_MAX || out_data.out_x == OUT_MIN
          || out_data.out_y == OUT_MAX || out_data.out_y == OUT_MIN
          || out_data.out_z == OUT_MAX || out_data.out_z == OUT_MIN))
        else $error("saturated flag set with no component at a bound");

endmodule
